// File: hdl/ipv4_cidr_text_parser_macros.svh
// Assertion macros for the IPv4 prefix-notation parser checks.
`ifndef IPV4_CIDR_TEXT_PARSER_MACROS_SVH
`define IPV4_CIDR_TEXT_PARSER_MACROS_SVH

// Clocked check, off while reset is asserted.
`define IPCIDR_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define IPCIDR_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ipcidr_pkg.sv
// Shared constants and types of the IPv4 prefix-notation parser.
package ipcidr_pkg;

    localparam int MAX_ADDR_CHARS = 16;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 104;
    localparam int RES_W     = 101;

    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    typedef struct packed {
        logic        in_prefix;
        logic        prefix_seen;
        logic        error;
        logic [5:0]  prefix;
        logic [31:0] address;
    } t_parse_view;

    typedef struct packed {
        logic        valid;
        logic [31:0] netmask;
        logic [31:0] last_host;
        logic [31:0] first_host;
        logic [4:0]  prefix;
    } t_result;

endpackage

// File: hdl/ipcidr_char_fsm.sv
// Per-character parse state machine: octet and prefix accumulators, error flag.
module ipcidr_char_fsm
    import ipcidr_pkg::*;
#(
    parameter int ADDR_CHARS = MAX_ADDR_CHARS
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    output t_parse_view o_next
);

    typedef enum logic [1:0] {
        PH_ADDR   = 2'd0,
        PH_PREFIX = 2'd1
    } t_phase;

    localparam logic [5:0] MAX_POS = 6'(ADDR_CHARS);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos,   n_pos;
    logic [7:0]  r_oct,   n_oct;
    logic [1:0]  r_cnt,   n_cnt;
    logic [1:0]  r_idx,   n_idx;
    logic        r_lz,    n_lz;
    logic [31:0] r_addr,  n_addr;
    logic [5:0]  r_pfx,   n_pfx;
    logic        r_seen,  n_seen;
    logic        r_err,   n_err;

    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] oct_acc;
    logic [8:0]  pfx_acc;
    logic [5:0]  pos_cur;
    logic [5:0]  pos_inc;

    always_comb begin
        is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        digit    = 4'(i_char - CH_ZERO);
        oct_acc  = {4'd0, r_oct} * 12'd10 + {8'd0, digit};
        pfx_acc  = {3'd0, r_pfx} * 9'd10 + {5'd0, digit};
        pos_cur  = {1'b0, r_pos};
        pos_inc  = pos_cur + 6'd1;

        n_phase = r_phase;
        n_pos   = r_pos;
        n_oct   = r_oct;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_lz    = r_lz;
        n_addr  = r_addr;
        n_pfx   = r_pfx;
        n_seen  = r_seen;
        n_err   = r_err;

        if (!r_err) begin
            unique case (r_phase)
                PH_ADDR: begin
                    if (i_char == CH_SLASH) begin
                        if (pos_cur >= MAX_POS || i_last || r_cnt == 2'd0
                                || r_idx != 2'd3) begin
                            n_err = 1'b1;
                        end else begin
                            n_addr  = {r_addr[23:0], r_oct};
                            n_phase = PH_PREFIX;
                        end
                    end else if (pos_inc >= MAX_POS) begin
                        n_err = 1'b1;
                    end else if (is_digit) begin
                        if (r_cnt != 2'd0 && r_lz) begin
                            n_err = 1'b1;
                        end else if (oct_acc > 12'd255) begin
                            n_err = 1'b1;
                        end else begin
                            if (r_cnt == 2'd0) begin
                                n_lz = (digit == 4'd0);
                            end
                            n_oct = oct_acc[7:0];
                            if (r_cnt != 2'd3) begin
                                n_cnt = r_cnt + 2'd1;
                            end
                        end
                    end else if (i_char == CH_DOT) begin
                        if (r_cnt == 2'd0 || r_idx == 2'd3) begin
                            n_err = 1'b1;
                        end else begin
                            n_addr = {r_addr[23:0], r_oct};
                            n_idx  = r_idx + 2'd1;
                            n_oct  = 8'd0;
                            n_cnt  = 2'd0;
                            n_lz   = 1'b0;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    if (is_digit) begin
                        n_pfx  = (pfx_acc > 9'd32) ? 6'd32 : pfx_acc[5:0];
                        n_seen = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end

        if (r_pos != 5'd31) begin
            n_pos = r_pos + 5'd1;
        end

        o_next.in_prefix   = (n_phase == PH_PREFIX);
        o_next.prefix_seen = n_seen;
        o_next.error       = n_err;
        o_next.prefix      = n_pfx;
        o_next.address     = n_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_ADDR;
            r_pos   <= 5'd0;
            r_oct   <= 8'd0;
            r_cnt   <= 2'd0;
            r_idx   <= 2'd0;
            r_lz    <= 1'b0;
            r_addr  <= 32'd0;
            r_pfx   <= 6'd0;
            r_seen  <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_oct   <= n_oct;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_lz    <= n_lz;
            r_addr  <= n_addr;
            r_pfx   <= n_pfx;
            r_seen  <= n_seen;
            r_err   <= n_err;
        end
    end

endmodule

// File: hdl/ipcidr_result_calc.sv
// Final checks on the parsed string and host range / netmask computation.
module ipcidr_result_calc
    import ipcidr_pkg::*;
(
    input  t_parse_view i_view,
    output t_result     o_res
);

    logic [31:0] hostmask;
    logic        ok;

    always_comb begin
        hostmask = ALL_ONES >> i_view.prefix;
        ok = !i_view.error && i_view.in_prefix && i_view.prefix_seen
            && (i_view.prefix >= 6'd1) && (i_view.prefix <= 6'd31)
            && (i_view.address != 32'd0) && ((i_view.address & hostmask) == 32'd0);

        o_res = '0;
        if (ok) begin
            o_res.valid      = 1'b1;
            o_res.prefix     = i_view.prefix[4:0];
            o_res.first_host = i_view.address + 32'd1;
            o_res.last_host  = (i_view.address | hostmask) - 32'd1;
            o_res.netmask    = ~hostmask;
        end
    end

endmodule

// File: hdl/ipv4_cidr_text_parser.sv
// Top level of the IPv4 prefix-notation (A.B.C.D/E) text parser.
//
// Slave stream: one ASCII character per beat on i_s_tdata, i_s_tlast on the
// final character of the string. Master stream: one result beat per string,
// o_m_tuser = 1 when the string is a valid prefix, o_m_tdata carries the
// prefix length, first host, last host and netmask (all zero when invalid).
// A character beat is taken every cycle unless a tlast beat waits for the result
// register; each beat is registered in the input register, then the parse state
// and the result register update from it. A tlast beat passes through the input
// register, then the result register, before its result is valid.
// Throughput: one character per cycle while no tlast beat waits.
// A stalled master holds the result register; the parser keeps taking
// characters until the next tlast beat has to wait for that register.
// Reset (synchronous, active low) clears the input and result valid flags and
// returns the parser to the start of a string; o_s_tready is high after it.
module ipv4_cidr_text_parser
    import ipcidr_pkg::*;
#(
    parameter int ADDR_CHARS = MAX_ADDR_CHARS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // [7:0] char_code
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // [4:0] prefix_length, [36:5] first_host,
                                             // [68:37] last_host, [100:69] netmask, rest 0
    output logic                 o_m_tuser   // [0] valid_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        consume;
    t_parse_view next_view;
    t_result     res;

    assign out_free   = !r_out_valid || i_m_tready;
    assign consume    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || consume;

    ipcidr_char_fsm #(
        .ADDR_CHARS (ADDR_CHARS)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (consume),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_next  (next_view)
    );

    ipcidr_result_calc u_calc (
        .i_view (next_view),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (consume && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata[7:0];
            r_in_last <= i_s_tlast;
        end
        if (consume && r_in_last) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.valid;
    assign o_m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, r_out.netmask, r_out.last_host,
                         r_out.first_host, r_out.prefix};

endmodule

// File: hdl/ipcidr_checker.sv
// Port-level checks of the IPv4 prefix-notation parser, bound to the top level.
`include "ipv4_cidr_text_parser_macros.svh"

module ipcidr_checker
    import ipcidr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] o_m_tdata,
    input  logic                 o_m_tuser
);

    logic [31:0] span;
    logic [31:0] hostspan;

    assign span     = o_m_tdata[68:37] - o_m_tdata[36:5];
    assign hostspan = ~o_m_tdata[100:69] - 32'd2;

    `IPCIDR_ASSERT_RUN(a_hold_on_stall, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result beat changed while stalled")
    `IPCIDR_ASSERT_RUN(a_invalid_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0, "invalid result carries nonzero data")
    `IPCIDR_ASSERT_RUN(a_valid_prefix, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> o_m_tdata[4:0] != 5'd0, "valid result with zero prefix")
    `IPCIDR_ASSERT_RUN(a_host_span, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> span == hostspan, "host range does not match netmask")
    `IPCIDR_ASSERT_ALL(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")

endmodule

bind ipv4_cidr_text_parser ipcidr_checker u_ipcidr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
